[rtl/tkl_pkg.sv]
// Shared types, constants and coefficient table for the type K linearizer.
package tkl_pkg;

  // Segment codes
  localparam logic [1:0] SEG_NEG  = 2'd0;
  localparam logic [1:0] SEG_LOW  = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  localparam int unsigned ACC_W  = 63;  // Horner partial sum, +-2^61
  localparam int unsigned MAG_W  = 62;  // magnitude up to 2^61
  localparam int unsigned UX_W   = 17;  // |voltage| up to 65536
  localparam int unsigned LIMB_W = 16;
  localparam int unsigned NLIMB  = 4;
  localparam int unsigned PAD_W  = NLIMB * LIMB_W;
  localparam int unsigned Q_W    = 66;  // quotient before clamp
  localparam int unsigned QC_W   = 21;  // quotient digit per limb
  localparam int unsigned REM_W  = 12;  // remainder mod 4000
  localparam int unsigned V_W    = 33;  // partial dividend per limb

  // 4000 = 125 * 2^5; divide by 125 through a reciprocal
  localparam int unsigned DIV_SH      = 5;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [21:0] RECIP_125   = 22'(64'd268435456 / 64'd125);
  localparam logic [10:0] ROUND_HALF  = 11'd2000;

  localparam logic [MAG_W-1:0] SAT_MAG = 62'h2000000000000000;
  localparam logic signed [63:0] SUM_HI = 64'sh2000000000000000;
  localparam logic signed [63:0] SUM_LO = -64'sh2000000000000000;

  // Item tag that rides along the whole pipeline
  typedef struct packed {
    logic [1:0]      seg;
    logic [UX_W-1:0] ux;
    logic            uneg;
  } tag_t;

  // Between Horner cells
  typedef struct packed {
    logic                    vld;
    tag_t                    tag;
    logic signed [ACC_W-1:0] acc;
  } hpipe_t;

  // Between limb steps inside a Horner cell
  typedef struct packed {
    logic             vld;
    tag_t             tag;
    logic             pneg;
    logic [PAD_W-1:0] mag;
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] rem;
    logic [QC_W-1:0]  qc;
  } lpipe_t;

  // Decimal coefficient: value = mag / 10^dexp, sign in neg
  typedef struct packed {
    logic [31:0] mag;
    logic [3:0]  dexp;
    logic        neg;
  } coef_t;

  localparam coef_t SEG_COEF [3][10] = '{
    '{ '{32'd0, 4'd0, 1'b0},        '{32'd25173462, 4'd6, 1'b0},
       '{32'd11662878, 4'd7, 1'b1}, '{32'd10833638, 4'd7, 1'b1},
       '{32'd89773540, 4'd8, 1'b1}, '{32'd37342377, 4'd8, 1'b1},
       '{32'd86632643, 4'd9, 1'b1}, '{32'd10450598, 4'd9, 1'b1},
       '{32'd51920577, 4'd11, 1'b1}, '{32'd0, 4'd0, 1'b0} },
    '{ '{32'd0, 4'd0, 1'b0},        '{32'd2508355, 4'd5, 1'b0},
       '{32'd7860106, 4'd8, 1'b0},  '{32'd2503131, 4'd7, 1'b1},
       '{32'd8315270, 4'd8, 1'b0},  '{32'd1228034, 4'd8, 1'b1},
       '{32'd9804036, 4'd10, 1'b0}, '{32'd4413030, 4'd11, 1'b1},
       '{32'd1057734, 4'd12, 1'b0}, '{32'd1052755, 4'd14, 1'b1} },
    '{ '{32'd1318058, 4'd4, 1'b1},  '{32'd4830222, 4'd5, 1'b0},
       '{32'd1646031, 4'd6, 1'b1},  '{32'd5464731, 4'd8, 1'b0},
       '{32'd9650715, 4'd10, 1'b1}, '{32'd8802193, 4'd12, 1'b0},
       '{32'd3110810, 4'd14, 1'b1}, '{32'd0, 4'd0, 1'b0},
       '{32'd0, 4'd0, 1'b0},        '{32'd0, 4'd0, 1'b0} }
  };

  // Coefficient j of segment s in Q(40+2j), rounded half away from zero.
  // Elaboration only: binary long division of mag * 2^fb by 10^dexp.
  function automatic logic signed [63:0] coef_fixed(input int unsigned s,
                                                    input int unsigned j);
    coef_t       cf;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    int unsigned fb;
    int          k;
    cf = SEG_COEF[s][j];
    fb = 40 + 2 * j;
    d  = 64'd1;
    q  = 64'd0;
    r  = 64'd0;
    for (k = 0; k < 15; k++) begin
      if (k < int'(cf.dexp)) begin
        d = d * 64'd10;
      end
    end
    for (k = 31; k >= 0; k--) begin
      r = {r[62:0], cf.mag[k]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q = q + 64'd1;
      end
    end
    for (k = 0; k < 60; k++) begin
      if (k < int'(fb)) begin
        r = {r[62:0], 1'b0};
        q = {q[62:0], 1'b0};
        if (r >= d) begin
          r = r - d;
          q = q + 64'd1;
        end
      end
    end
    if ({r[62:0], 1'b0} >= d) begin
      q = q + 64'd1;
    end
    return cf.neg ? -$signed(q) : $signed(q);
  endfunction

endpackage

[rtl/tkl_limb.sv]
// One 16-bit limb step of the multiply by |x| and divide by 4000.
module tkl_limb #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tkl_pkg::lpipe_t lin,
  output tkl_pkg::lpipe_t lout
);

  typedef struct packed {
    logic                          vld;
    tkl_pkg::tag_t                 tag;
    logic                          pneg;
    logic [tkl_pkg::PAD_W-1:0]     mag;
    logic [tkl_pkg::Q_W-1:0]       q;
    logic [tkl_pkg::V_W-1:0]       v;
  } s1_t;

  typedef struct packed {
    logic                          vld;
    tkl_pkg::tag_t                 tag;
    logic                          pneg;
    logic [tkl_pkg::PAD_W-1:0]     mag;
    logic [tkl_pkg::Q_W-1:0]       q;
    logic [tkl_pkg::V_W-1:0]       v;
    logic [tkl_pkg::QC_W-1:0]      q0;
  } s2_t;

  localparam int unsigned LSB = IDX * tkl_pkg::LIMB_W;
  localparam int unsigned W_W = tkl_pkg::V_W - tkl_pkg::DIV_SH;
  localparam int unsigned RP_W = W_W + 22;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  tkl_pkg::lpipe_t lout_r, lout_nxt;

  logic [tkl_pkg::LIMB_W-1:0] limb;
  logic [tkl_pkg::V_W-1:0]    pp;
  logic [tkl_pkg::V_W-1:0]    bias;
  logic [RP_W-1:0]            rp;
  logic [7:0]                 r0;
  logic                       fix;
  logic [7:0]                 r1;

  // Stage 1: carry-in remainder * 2^16 + limb * |x| (+2000 on limb 0); fold previous digit into q
  assign limb = lin.mag[LSB +: tkl_pkg::LIMB_W];
  assign pp   = tkl_pkg::V_W'(limb) * tkl_pkg::V_W'(lin.tag.ux);
  assign bias = (IDX == 0) ? tkl_pkg::V_W'(tkl_pkg::ROUND_HALF) : '0;

  always_comb begin
    s1_nxt.vld  = lin.vld;
    s1_nxt.tag  = lin.tag;
    s1_nxt.pneg = lin.pneg;
    s1_nxt.mag  = lin.mag;
    s1_nxt.q    = {lin.q[tkl_pkg::Q_W-tkl_pkg::LIMB_W-1:0], {tkl_pkg::LIMB_W{1'b0}}}
                  + tkl_pkg::Q_W'(lin.qc);
    s1_nxt.v    = tkl_pkg::V_W'({lin.rem, {tkl_pkg::LIMB_W{1'b0}}}) + pp + bias;
  end

  // Stage 2: estimate (v >> 5) / 125, low by at most one
  assign rp = RP_W'(s1_r.v[tkl_pkg::V_W-1:tkl_pkg::DIV_SH]) * RP_W'(tkl_pkg::RECIP_125);

  always_comb begin
    s2_nxt.vld  = s1_r.vld;
    s2_nxt.tag  = s1_r.tag;
    s2_nxt.pneg = s1_r.pneg;
    s2_nxt.mag  = s1_r.mag;
    s2_nxt.q    = s1_r.q;
    s2_nxt.v    = s1_r.v;
    s2_nxt.q0   = rp[tkl_pkg::RECIP_SHIFT +: tkl_pkg::QC_W];
  end

  // Stage 3: remainder below 250 fits 8 bits, one correction step
  assign r0  = s2_r.v[tkl_pkg::DIV_SH +: 8] - 8'(16'(s2_r.q0[7:0]) * 16'd125);
  assign fix = (r0 >= 8'd125);
  assign r1  = fix ? (r0 - 8'd125) : r0;

  always_comb begin
    lout_nxt.vld  = s2_r.vld;
    lout_nxt.tag  = s2_r.tag;
    lout_nxt.pneg = s2_r.pneg;
    lout_nxt.mag  = s2_r.mag;
    lout_nxt.q    = s2_r.q;
    lout_nxt.qc   = s2_r.q0 + tkl_pkg::QC_W'(fix);
    lout_nxt.rem  = {r1[6:0], s2_r.v[tkl_pkg::DIV_SH-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld   <= 1'b0;
      s2_r.vld   <= 1'b0;
      lout_r.vld <= 1'b0;
    end else begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      lout_r <= lout_nxt;
    end
  end

  assign lout = lout_r;

endmodule

[rtl/tkl_horner_cell.sv]
// One Horner step: acc = sat(round(acc * x / 4000) + c_j), limb-serial divide.
module tkl_horner_cell #(
  parameter int unsigned J = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tkl_pkg::hpipe_t hin,
  output tkl_pkg::hpipe_t hout
);

  typedef struct packed {
    logic                      vld;
    tkl_pkg::tag_t             tag;
    logic                      pneg;
    logic [tkl_pkg::MAG_W-1:0] m;
  } fin_t;

  localparam logic signed [tkl_pkg::ACC_W-1:0] C_NEG  =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(0, J));
  localparam logic signed [tkl_pkg::ACC_W-1:0] C_LOW  =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(1, J));
  localparam logic signed [tkl_pkg::ACC_W-1:0] C_HIGH =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(2, J));

  tkl_pkg::lpipe_t e_r, e_nxt;
  tkl_pkg::lpipe_t lk [0:tkl_pkg::NLIMB];
  fin_t            f_r, f_nxt;
  tkl_pkg::hpipe_t hout_r, hout_nxt;

  logic [tkl_pkg::ACC_W-1:0]  amag;
  logic [tkl_pkg::Q_W-1:0]    qf;
  logic signed [tkl_pkg::ACC_W-1:0] coef;
  logic signed [63:0]         sum;

  // Entry: sign/magnitude split
  assign amag = hin.acc[tkl_pkg::ACC_W-1] ? tkl_pkg::ACC_W'(-hin.acc)
                                          : tkl_pkg::ACC_W'(hin.acc);

  always_comb begin
    e_nxt      = '0;
    e_nxt.vld  = hin.vld;
    e_nxt.tag  = hin.tag;
    e_nxt.pneg = hin.acc[tkl_pkg::ACC_W-1] ^ hin.tag.uneg;
    e_nxt.mag  = tkl_pkg::PAD_W'(amag);
  end

  assign lk[tkl_pkg::NLIMB] = e_r;

  // Most significant limb first
  for (genvar i = 0; i < tkl_pkg::NLIMB; i++) begin : g_limb
    tkl_limb #(.IDX(i)) u_limb (
      .clk  (clk),
      .rst_n(rst_n),
      .lin  (lk[i+1]),
      .lout (lk[i])
    );
  end

  // Final digit, clamp magnitude at 2^61
  assign qf = {lk[0].q[tkl_pkg::Q_W-tkl_pkg::LIMB_W-1:0], {tkl_pkg::LIMB_W{1'b0}}}
              + tkl_pkg::Q_W'(lk[0].qc);

  always_comb begin
    f_nxt.vld  = lk[0].vld;
    f_nxt.tag  = lk[0].tag;
    f_nxt.pneg = lk[0].pneg;
    f_nxt.m    = (qf > tkl_pkg::Q_W'(tkl_pkg::SAT_MAG)) ? tkl_pkg::SAT_MAG
                                                        : qf[tkl_pkg::MAG_W-1:0];
  end

  // Add coefficient, clamp to +-2^61
  always_comb begin
    case (f_r.tag.seg)
      tkl_pkg::SEG_NEG: coef = C_NEG;
      tkl_pkg::SEG_LOW: coef = C_LOW;
      default:          coef = C_HIGH;
    endcase
  end

  assign sum = f_r.pneg ? (64'(coef) - $signed(64'(f_r.m)))
                        : (64'(coef) + $signed(64'(f_r.m)));

  always_comb begin
    hout_nxt.vld = f_r.vld;
    hout_nxt.tag = f_r.tag;
    if (sum > tkl_pkg::SUM_HI) begin
      hout_nxt.acc = tkl_pkg::ACC_W'(tkl_pkg::SUM_HI);
    end else if (sum < tkl_pkg::SUM_LO) begin
      hout_nxt.acc = tkl_pkg::ACC_W'(tkl_pkg::SUM_LO);
    end else begin
      hout_nxt.acc = tkl_pkg::ACC_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.vld    <= 1'b0;
      f_r.vld    <= 1'b0;
      hout_r.vld <= 1'b0;
    end else begin
      e_r    <= e_nxt;
      f_r    <= f_nxt;
      hout_r <= hout_nxt;
    end
  end

  assign hout = hout_r;

endmodule

[rtl/thermocouple_type_k_linearize_core.sv]
// Type K thermocouple linearizer top: segment pick, nine Horner cells, Q16 rounding.
// Pipeline: entry register, nine Horner cells, rounding register, output register.
// Throughput: one item per cycle; busy stays low, there is no stall path.
// Each Horner cell is 15 stages deep
// (entry, four limb steps of three stages, clamp, coefficient add).
// Reset (rst_n low, synchronous) clears only the valid flags in the pipe.
module thermocouple_type_k_linearize_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [16:0] in_voltage_uv,
  output logic               out_valid,
  output logic signed [27:0] out_temperature_q16,
  output logic [1:0]         out_segment
);

  // Output limits, Q12.16: -300 C .. 1500 C
  localparam logic signed [27:0] TEMP_MAX = 28'sd98304000;
  localparam logic signed [27:0] TEMP_MIN = -28'sd19660800;
  localparam logic [37:0]        TMAX_MAG = 38'd98304000;
  localparam logic [37:0]        TMIN_MAG = 38'd19660800;
  localparam logic [tkl_pkg::MAG_W-1:0] Q16_HALF = 62'h800000;
  localparam logic signed [16:0] SEG1_LIMIT_UV = 17'sd20644;
  localparam int unsigned        NCELL = 9;

  // Highest-order coefficient seeds the Horner sum
  localparam logic signed [tkl_pkg::ACC_W-1:0] C9_NEG  =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(0, 9));
  localparam logic signed [tkl_pkg::ACC_W-1:0] C9_LOW  =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(1, 9));
  localparam logic signed [tkl_pkg::ACC_W-1:0] C9_HIGH =
    tkl_pkg::ACC_W'(tkl_pkg::coef_fixed(2, 9));

  typedef struct packed {
    logic                      vld;
    logic [1:0]                seg;
    logic                      neg;
    logic [tkl_pkg::MAG_W-1:0] mag;
  } rnd_t;

  tkl_pkg::hpipe_t h0_r, h0_nxt;
  tkl_pkg::hpipe_t hc [0:NCELL];
  rnd_t            rnd_r, rnd_nxt;

  logic                      accept;
  logic [1:0]                seg;
  logic [tkl_pkg::MAG_W-1:0] rsum;
  logic [37:0]               tmag;
  logic signed [27:0]        temp_nxt;

  logic               out_valid_r;
  logic signed [27:0] out_temperature_q16_r;
  logic [1:0]         out_segment_r;

  // The pipe never holds an item back, so a start is always taken
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Segment: non-positive, up to 20.644 mV, above
  always_comb begin
    if (in_voltage_uv <= 17'sd0) begin
      seg = tkl_pkg::SEG_NEG;
    end else if (in_voltage_uv <= SEG1_LIMIT_UV) begin
      seg = tkl_pkg::SEG_LOW;
    end else begin
      seg = tkl_pkg::SEG_HIGH;
    end
  end

  // Entry stage: |x| in microvolts (-65536 maps to 65536), sign, seed term
  always_comb begin
    h0_nxt.vld      = accept;
    h0_nxt.tag.seg  = seg;
    h0_nxt.tag.uneg = in_voltage_uv[16];
    h0_nxt.tag.ux   = in_voltage_uv[16] ? tkl_pkg::UX_W'(-in_voltage_uv)
                                        : tkl_pkg::UX_W'(in_voltage_uv);
    case (seg)
      tkl_pkg::SEG_NEG: h0_nxt.acc = C9_NEG;
      tkl_pkg::SEG_LOW: h0_nxt.acc = C9_LOW;
      default:          h0_nxt.acc = C9_HIGH;
    endcase
  end

  assign hc[NCELL] = h0_r;

  // Cell J consumes the sum of order J+1 and adds c_J; order 8 sits first
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    tkl_horner_cell #(.J(j)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .hin  (hc[j+1]),
      .hout (hc[j])
    );
  end

  // Q40 sum to sign and magnitude
  always_comb begin
    rnd_nxt.vld = hc[0].vld;
    rnd_nxt.seg = hc[0].tag.seg;
    rnd_nxt.neg = hc[0].acc[tkl_pkg::ACC_W-1];
    rnd_nxt.mag = hc[0].acc[tkl_pkg::ACC_W-1] ? tkl_pkg::MAG_W'(-hc[0].acc)
                                              : tkl_pkg::MAG_W'(hc[0].acc);
  end

  // Round magnitude to Q16 (half away from zero), restore sign, clamp
  assign rsum = rnd_r.mag + Q16_HALF;
  assign tmag = rsum[tkl_pkg::MAG_W-1:24];

  always_comb begin
    if (rnd_r.neg) begin
      temp_nxt = (tmag > TMIN_MAG) ? TEMP_MIN : -28'(tmag[26:0]);
    end else begin
      temp_nxt = (tmag > TMAX_MAG) ? TEMP_MAX : 28'(tmag[26:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_r.vld    <= 1'b0;
      rnd_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      h0_r                  <= h0_nxt;
      rnd_r                 <= rnd_nxt;
      out_valid_r           <= rnd_r.vld;
      out_temperature_q16_r <= temp_nxt;
      out_segment_r         <= rnd_r.seg;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature_q16 = out_temperature_q16_r;
  assign out_segment         = out_segment_r;

`ifndef NO_ASSERTIONS
  // Delivered temperatures stay inside the clamp window
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_q16 <= TEMP_MAX && out_temperature_q16 >= TEMP_MIN))
    else $error("temperature outside clamp range");

  // Last Horner cell never leaves its saturation bounds
  a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    hc[0].vld |-> (64'(hc[0].acc) <= tkl_pkg::SUM_HI &&
                   64'(hc[0].acc) >= tkl_pkg::SUM_LO))
    else $error("Horner sum beyond saturation bound");

  // Positive segments only come from positive voltages
  a_seg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (h0_r.vld && h0_r.tag.seg != tkl_pkg::SEG_NEG) |->
      (!h0_r.tag.uneg && h0_r.tag.ux != 17'd0))
    else $error("segment disagrees with voltage sign");
`endif

endmodule
